/* src/ihex_pkg.sv */
// Shared types, codes and a helper function for the Intel HEX stream parser.
// Depends on nothing; imported by ihex_rsp_reg and intel_hex_stream_parser.
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

   localparam int LINE_COUNT_BITS_DEFAULT = 16;

   // Result kinds.
   localparam logic [1:0] KIND_SEG  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_OK   = 2'd2;
   localparam logic [1:0] KIND_FAIL = 2'd3;

   // Error codes.
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_NO_COLON = 3'd1;
   localparam logic [2:0] ERR_HEADER   = 3'd2;
   localparam logic [2:0] ERR_TRUNC    = 3'd3;
   localparam logic [2:0] ERR_CHECKSUM = 3'd4;
   localparam logic [2:0] ERR_EXT_ADDR = 3'd5;
   localparam logic [2:0] ERR_NO_DATA  = 3'd6;

   // Record types.
   localparam logic [7:0] REC_DATA    = 8'h00;
   localparam logic [7:0] REC_EOF     = 8'h01;
   localparam logic [7:0] REC_EXT_LIN = 8'h04;

   // Characters of interest.
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // The header is length, offset high, offset low and type: eight digits.
   localparam logic [9:0] HEADER_DIGITS = 10'd8;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_REC  = 3'b010,
      PH_DONE = 3'b100
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [7:0]  data_byte;
      logic [2:0]  error_code;
      logic [15:0] line_number;
   } rsp_type;

   // Hex digit decode: bit 4 set means the character is a valid digit.
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* src/ihex_rsp_reg.sv */
// Result register with valid/stall handshake for the Intel HEX parser.
// Depends on ihex_pkg for the result record type.
`timescale 1ns / 1ps
`default_nettype none

module ihex_rsp_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load_valid,
   input  wire ihex_pkg::rsp_type load_data,
   output logic                  load_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ihex_pkg::rsp_type     rsp_data
);
   import ihex_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   logic    open_slot;

   // The register may take a new transaction when empty or when its
   // current one leaves in this cycle.
   assign open_slot  = !valid_ff || !rsp_stall;
   assign load_stall = !open_slot;
   assign valid_in   = open_slot ? load_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (open_slot && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

/* src/intel_hex_stream_parser.sv */
// Intel HEX stream parser: one character per transaction, one result at most.
// Each result is registered and appears in the cycle after the character that causes it.
// Throughput: one character per cycle; the input stalls only while a result
// waits in the output register and the output side stalls.
// Reset (synchronous, active high) returns to awaiting a line start with all
// addresses, counts and the segment flag cleared.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_stream_parser #(
   parameter int LINE_COUNT_BITS = ihex_pkg::LINE_COUNT_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_end_of_stream,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_address,
   output logic [7:0]       rsp_data_byte,
   output logic [2:0]       rsp_error_code,
   output logic [15:0]      rsp_line_number
);
   import ihex_pkg::*;

   localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = '1;

   phase_type                  phase_ff, phase_in;
   logic [9:0]                 digit_ff, digit_in;
   logic [7:0]                 len_ff, len_in;
   logic [15:0]                offset_ff, offset_in;
   logic [7:0]                 type_ff, type_in;
   logic [3:0]                 hnib_ff, hnib_in;
   logic [7:0]                 sum_ff, sum_in;
   logic [15:0]                upper_ff, upper_in;
   logic [15:0]                pending_ff, pending_in;
   logic [32:0]                next_ff, next_in;
   logic [31:0]                baddr_ff, baddr_in;
   logic                       have_ff, have_in;
   logic [LINE_COUNT_BITS-1:0] line_ff, line_in;

   logic                accept;
   logic                emit;
   logic [1:0]          e_kind;
   logic [31:0]         e_addr;
   logic [7:0]          e_data;
   logic [2:0]          e_err;
   logic [LINE_COUNT_BITS+15:0] line_ext;
   logic [15:0]         line_shown;
   rsp_type             load_data;
   rsp_type             rsp_data;

   logic [9:0]  total_digits;
   logic [8:0]  byte_idx;
   logic [8:0]  body_end;
   logic [4:0]  nib;
   logic [7:0]  v;
   logic [7:0]  sum_new;
   logic [2:0]  end_err;
   logic [31:0] seg_addr;

   assign accept       = req_valid && !req_stall;
   assign total_digits = {{1'b0, len_ff} + 9'd5, 1'b0};
   assign byte_idx     = digit_ff[9:1];
   assign body_end     = 9'd4 + {1'b0, len_ff};
   assign nib          = nibble_of(req_ch);
   assign v            = {hnib_ff, nib[3:0]};
   assign sum_new      = sum_ff + v;
   assign seg_addr     = {upper_ff, offset_ff};

   always_comb begin
      if (digit_ff < HEADER_DIGITS) begin
         end_err = ERR_HEADER;
      end else if (digit_ff < total_digits) begin
         end_err = ERR_TRUNC;
      end else begin
         end_err = ERR_NONE;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      digit_in   = digit_ff;
      len_in     = len_ff;
      offset_in  = offset_ff;
      type_in    = type_ff;
      hnib_in    = hnib_ff;
      sum_in     = sum_ff;
      upper_in   = upper_ff;
      pending_in = pending_ff;
      next_in    = next_ff;
      baddr_in   = baddr_ff;
      have_in    = have_ff;
      line_in    = line_ff;
      emit       = 1'b0;
      e_kind     = KIND_SEG;
      e_addr     = 32'd0;
      e_data     = 8'd0;
      e_err      = ERR_NONE;

      if (accept && phase_ff != PH_DONE) begin
         if (req_end_of_stream) begin
            emit = 1'b1;
            if (phase_ff == PH_REC && end_err != ERR_NONE) begin
               e_kind = KIND_FAIL;
               e_err  = end_err;
            end else if (have_ff) begin
               e_kind = KIND_OK;
            end else begin
               e_kind = KIND_FAIL;
               e_err  = ERR_NO_DATA;
            end
         end else if (req_ch == CHAR_CR) begin
            // Carriage returns are dropped wherever they fall.
         end else if (phase_ff == PH_IDLE) begin
            if (line_ff != LINE_MAX) begin
               line_in = line_ff + LINE_COUNT_BITS'(1);
            end
            if (req_ch == CHAR_LF) begin
               // An empty line counts but carries nothing.
            end else if (req_ch != CHAR_COLON) begin
               emit   = 1'b1;
               e_kind = KIND_FAIL;
               e_err  = ERR_NO_COLON;
            end else begin
               phase_in = PH_REC;
               digit_in = 10'd0;
               sum_in   = 8'd0;
               len_in   = 8'd0;
            end
         end else if (req_ch == CHAR_LF) begin
            if (end_err != ERR_NONE) begin
               emit   = 1'b1;
               e_kind = KIND_FAIL;
               e_err  = end_err;
            end else begin
               phase_in = PH_IDLE;
            end
         end else if (digit_ff >= HEADER_DIGITS && digit_ff >= total_digits) begin
            // Text after the checksum byte is ignored up to the line end.
         end else if (!nib[4]) begin
            emit   = 1'b1;
            e_kind = KIND_FAIL;
            e_err  = (digit_ff < HEADER_DIGITS) ? ERR_HEADER : ERR_TRUNC;
         end else if (!digit_ff[0]) begin
            hnib_in  = nib[3:0];
            digit_in = digit_ff + 10'd1;
         end else begin
            digit_in = digit_ff + 10'd1;
            sum_in   = sum_new;
            if (byte_idx == 9'd0) begin
               len_in = v;
            end else if (byte_idx == 9'd1) begin
               offset_in = {v, 8'd0};
            end else if (byte_idx == 9'd2) begin
               offset_in = {offset_ff[15:8], v};
            end else if (byte_idx == 9'd3) begin
               type_in = v;
               if (v == REC_EXT_LIN) begin
                  pending_in = 16'd0;
               end
               if (v == REC_DATA) begin
                  // A data record continues the segment only when it starts
                  // exactly where the previous one ended.
                  have_in  = 1'b1;
                  baddr_in = seg_addr;
                  next_in  = {1'b0, seg_addr} + {25'd0, len_ff};
                  if (!have_ff || next_ff != {1'b0, seg_addr}) begin
                     emit   = 1'b1;
                     e_kind = KIND_SEG;
                     e_addr = seg_addr;
                  end
               end
            end else if (byte_idx < body_end) begin
               if (type_ff == REC_EXT_LIN) begin
                  pending_in = {pending_ff[7:0], v};
               end
               if (type_ff == REC_DATA) begin
                  emit     = 1'b1;
                  e_kind   = KIND_DATA;
                  e_addr   = baddr_ff;
                  e_data   = v;
                  baddr_in = baddr_ff + 32'd1;
               end
            end else begin
               if (sum_new != 8'd0) begin
                  emit   = 1'b1;
                  e_kind = KIND_FAIL;
                  e_err  = ERR_CHECKSUM;
               end else if (type_ff == REC_EOF) begin
                  emit = 1'b1;
                  if (have_ff) begin
                     e_kind = KIND_OK;
                  end else begin
                     e_kind = KIND_FAIL;
                     e_err  = ERR_NO_DATA;
                  end
               end else if (type_ff == REC_EXT_LIN) begin
                  if (len_ff != 8'd2) begin
                     emit   = 1'b1;
                     e_kind = KIND_FAIL;
                     e_err  = ERR_EXT_ADDR;
                  end else begin
                     upper_in = pending_ff;
                  end
               end
            end
         end

         if (emit && (e_kind == KIND_OK || e_kind == KIND_FAIL)) begin
            phase_in = PH_DONE;
         end
      end
   end

   // The line number shown saturates at the width of the result field.
   assign line_ext   = {16'd0, line_in};
   assign line_shown = (|line_ext[LINE_COUNT_BITS+15:16]) ? 16'hFFFF : line_ext[15:0];

   always_comb begin
      load_data.kind        = e_kind;
      load_data.address     = e_addr;
      load_data.data_byte   = e_data;
      load_data.error_code  = e_err;
      load_data.line_number = (e_kind == KIND_OK || e_kind == KIND_FAIL) ? line_shown : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         digit_ff   <= 10'd0;
         len_ff     <= 8'd0;
         offset_ff  <= 16'd0;
         type_ff    <= 8'd0;
         hnib_ff    <= 4'd0;
         sum_ff     <= 8'd0;
         upper_ff   <= 16'd0;
         pending_ff <= 16'd0;
         next_ff    <= 33'd0;
         baddr_ff   <= 32'd0;
         have_ff    <= 1'b0;
         line_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         digit_ff   <= digit_in;
         len_ff     <= len_in;
         offset_ff  <= offset_in;
         type_ff    <= type_in;
         hnib_ff    <= hnib_in;
         sum_ff     <= sum_in;
         upper_ff   <= upper_in;
         pending_ff <= pending_in;
         next_ff    <= next_in;
         baddr_ff   <= baddr_in;
         have_ff    <= have_in;
         line_ff    <= line_in;
      end
   end

   ihex_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (emit),
      .load_data  (load_data),
      .load_stall (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   assign rsp_kind        = rsp_data.kind;
   assign rsp_address     = rsp_data.address;
   assign rsp_data_byte   = rsp_data.data_byte;
   assign rsp_error_code  = rsp_data.error_code;
   assign rsp_line_number = rsp_data.line_number;

endmodule

`default_nettype wire

/* tb/sv/intel_hex_stream_parser_tb.sv */
// Self-checking bench for the Intel HEX stream parser: one load of generated hex text.
// Relies on ihex_pkg for codes and the result type, and on intel_hex_stream_parser.
`timescale 1ns / 1ps

module intel_hex_stream_parser_tb;
   import ihex_pkg::*;

   localparam realtime HALF_PERIOD = 1.0;
   localparam int RESET_CYCLES = 7;
   localparam int CYCLE_LIMIT = 500000;
   localparam int TEXT_CHARS = 1000;
   localparam int MODE_SPAN = 128;
   localparam int DRAIN_CYCLES = 8;
   localparam int NOISE_CHARS = 20;

   typedef struct packed {
      logic [7:0] ch;
      logic       eos;
   } char_item;

   // Shadow of the parser: follows every accepted character and queues the
   // results that it must give, in order.
   class hex_load_tracker;
      rsp_type     pending_results[$];
      int unsigned faults;
      phase_type   phase;
      logic [9:0]  digit_pos;
      logic [7:0]  rec_len;
      logic [15:0] rec_off;
      logic [7:0]  rec_type;
      logic [3:0]  hi_digit;
      logic [7:0]  byte_sum;
      logic [15:0] upper_addr;
      logic [15:0] staged_upper;
      logic [32:0] seg_end;
      logic [31:0] byte_addr;
      bit          seg_open;
      logic [15:0] lines_begun;

      function new();
         faults = 0;
         phase = PH_IDLE;
         digit_pos = '0;
         rec_len = '0;
         rec_off = '0;
         rec_type = '0;
         hi_digit = '0;
         byte_sum = '0;
         upper_addr = '0;
         staged_upper = '0;
         seg_end = '0;
         byte_addr = '0;
         seg_open = 1'b0;
         lines_begun = '0;
      endfunction

      function void post(logic [1:0] k, logic [31:0] a, logic [7:0] d, logic [2:0] e);
         rsp_type r;
         r.kind = k;
         r.address = a;
         r.data_byte = d;
         r.error_code = e;
         r.line_number = (k == KIND_OK || k == KIND_FAIL) ? lines_begun : 16'd0;
         if (k == KIND_OK || k == KIND_FAIL) begin
            phase = PH_DONE;
         end
         pending_results.insert(pending_results.size(), r);
      endfunction

      function void finish_load();
         if (seg_open) begin
            post(KIND_OK, 32'd0, 8'd0, ERR_NONE);
         end else begin
            post(KIND_FAIL, 32'd0, 8'd0, ERR_NO_DATA);
         end
      endfunction

      function int digit_total();
         return (int'(rec_len) + 5) * 2;
      endfunction

      function logic [2:0] line_fault();
         if (digit_pos < HEADER_DIGITS) return ERR_HEADER;
         if (int'(digit_pos) < digit_total()) return ERR_TRUNC;
         return ERR_NONE;
      endfunction

      function int hex_value(logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
         if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
         if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
         return -1;
      endfunction

      function void absorb_byte(logic [7:0] v);
         int          idx;
         logic [31:0] a;
         bit          opens;
         idx = int'(digit_pos >> 1);
         byte_sum = byte_sum + v;
         if (idx == 0) begin
            rec_len = v;
         end else if (idx == 1) begin
            rec_off = {v, 8'h00};
         end else if (idx == 2) begin
            rec_off[7:0] = v;
         end else if (idx == 3) begin
            rec_type = v;
            if (v == REC_EXT_LIN) begin
               staged_upper = '0;
            end
            if (v == REC_DATA) begin
               a = {upper_addr, rec_off};
               // A record continues the segment only if it starts exactly at its end.
               opens = !seg_open || seg_end != {1'b0, a};
               seg_open = 1'b1;
               byte_addr = a;
               seg_end = {1'b0, a} + 33'(rec_len);
               if (opens) begin
                  post(KIND_SEG, a, 8'd0, ERR_NONE);
               end
            end
         end else if (idx < 4 + int'(rec_len)) begin
            if (rec_type == REC_EXT_LIN) begin
               staged_upper = {staged_upper[7:0], v};
            end
            if (rec_type == REC_DATA) begin
               post(KIND_DATA, byte_addr, v, ERR_NONE);
               byte_addr = byte_addr + 32'd1;
            end
         end else if (byte_sum != 8'd0) begin
            post(KIND_FAIL, 32'd0, 8'd0, ERR_CHECKSUM);
         end else if (rec_type == REC_EOF) begin
            finish_load();
         end else if (rec_type == REC_EXT_LIN) begin
            if (rec_len != 8'd2) begin
               post(KIND_FAIL, 32'd0, 8'd0, ERR_EXT_ADDR);
            end else begin
               upper_addr = staged_upper;
            end
         end
      endfunction

      function void take_char(logic [7:0] c, logic eos);
         int         nib;
         logic [2:0] e;
         if (phase == PH_DONE) return;
         if (eos) begin
            if (phase == PH_REC) begin
               e = line_fault();
               if (e != ERR_NONE) begin
                  post(KIND_FAIL, 32'd0, 8'd0, e);
                  return;
               end
            end
            finish_load();
            return;
         end
         if (c == CHAR_CR) return;
         if (phase == PH_IDLE) begin
            if (lines_begun != 16'hFFFF) begin
               lines_begun = lines_begun + 16'd1;
            end
            if (c == CHAR_LF) return;
            if (c != CHAR_COLON) begin
               post(KIND_FAIL, 32'd0, 8'd0, ERR_NO_COLON);
               return;
            end
            phase = PH_REC;
            digit_pos = '0;
            byte_sum = '0;
            rec_len = '0;
            return;
         end
         if (c == CHAR_LF) begin
            e = line_fault();
            if (e != ERR_NONE) begin
               post(KIND_FAIL, 32'd0, 8'd0, e);
            end else begin
               phase = PH_IDLE;
            end
            return;
         end
         // Anything after the checksum byte is passed over up to the line end.
         if (int'(digit_pos) >= digit_total()) return;
         nib = hex_value(c);
         if (nib < 0) begin
            post(KIND_FAIL, 32'd0, 8'd0, (digit_pos < HEADER_DIGITS) ? ERR_HEADER : ERR_TRUNC);
            return;
         end
         if (!digit_pos[0]) begin
            hi_digit = 4'(nib);
            digit_pos = digit_pos + 10'd1;
            return;
         end
         absorb_byte({hi_digit, 4'(nib)});
         digit_pos = digit_pos + 10'd1;
      endfunction

      function void report(string what, rsp_type want, rsp_type got);
         faults++;
         if (faults <= 10) begin
            $display("%0t %s: expected kind %0d addr %h byte %h err %0d line %0d", $time,
                     what, want.kind, want.address, want.data_byte, want.error_code,
                     want.line_number);
            $display("   got kind %0d addr %h byte %h err %0d line %0d", got.kind,
                     got.address, got.data_byte, got.error_code, got.line_number);
         end
      endfunction

      function void compare_output(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            report("unexpected result", '0, got);
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind || got.address !== want.address ||
             got.data_byte !== want.data_byte || got.error_code !== want.error_code ||
             got.line_number !== want.line_number) begin
            report("result mismatch", want, got);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch = 8'h00;
   logic        req_end_of_stream = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_address;
   logic [7:0]  rsp_data_byte;
   logic [2:0]  rsp_error_code;
   logic [15:0] rsp_line_number;

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned cycle_count = 0;

   char_item    file_text[$];
   logic [7:0]  rec_bytes[$];
   logic [15:0] gen_upper = 16'h0000;
   logic [32:0] gen_next = '0;
   bit          long_record_sent = 1'b0;

   hex_load_tracker load_tracker = new();

   intel_hex_stream_parser i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ch            (req_ch),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_address       (rsp_address),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_error_code    (rsp_error_code),
      .rsp_line_number   (rsp_line_number)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      rsp_type seen;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            load_tracker.take_char(req_ch, req_end_of_stream);
         end
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_kind, rsp_address, rsp_data_byte, rsp_error_code, rsp_line_number};
            load_tracker.compare_output(seen);
         end
      end
   end

   // Appends one character to the end of the generated text.
   function automatic void add_text_char(char_item c);
      file_text.insert(file_text.size(), c);
   endfunction

   // Appends one byte to the body of the record being built.
   function automatic void add_rec_byte(logic [7:0] b);
      rec_bytes.insert(rec_bytes.size(), b);
   endfunction

   function automatic logic [7:0] digit_char(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   // A stray carriage return may fall anywhere in the text.
   function automatic void put_char(logic [7:0] c);
      if ($urandom_range(99) < 3) begin
         add_text_char({CHAR_CR, 1'b0});
      end
      add_text_char({c, 1'b0});
   endfunction

   function automatic void put_eos();
      add_text_char({8'($urandom), 1'b1});
   endfunction

   function automatic void put_hex_byte(logic [7:0] b);
      put_char(digit_char(b[7:4]));
      put_char(digit_char(b[3:0]));
   endfunction

   function automatic logic [7:0] pick_non_hex();
      logic [7:0] c;
      do begin
         c = 8'($urandom);
      end while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                 (c >= 8'h61 && c <= 8'h66) || c == CHAR_LF || c == CHAR_CR);
      return c;
   endfunction

   function automatic logic [15:0] pick_upper();
      case ($urandom_range(3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Writes a record around rec_bytes; a non-zero skew spoils the checksum.
   function automatic void put_record(logic [7:0] typ, logic [15:0] off, logic [7:0] skew);
      logic [7:0] sum;
      sum = 8'(rec_bytes.size()) + off[15:8] + off[7:0] + typ;
      foreach (rec_bytes[i]) sum = sum + rec_bytes[i];
      put_char(CHAR_COLON);
      put_hex_byte(8'(rec_bytes.size()));
      put_hex_byte(off[15:8]);
      put_hex_byte(off[7:0]);
      put_hex_byte(typ);
      foreach (rec_bytes[i]) put_hex_byte(rec_bytes[i]);
      put_hex_byte(8'd0 - sum + skew);
   endfunction

   function automatic void put_line_end();
      logic [7:0] c;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            do begin
               c = 8'($urandom);
            end while (c == CHAR_LF);
            add_text_char({c, 1'b0});
         end
      end
      if ($urandom_range(1)) begin
         add_text_char({CHAR_CR, 1'b0});
      end
      add_text_char({CHAR_LF, 1'b0});
   endfunction

   function automatic void put_ext(logic [15:0] u);
      rec_bytes = {u[15:8], u[7:0]};
      put_record(REC_EXT_LIN, $urandom_range(1) ? 16'($urandom) : 16'h0000, 8'd0);
      put_line_end();
      gen_upper = u;
   endfunction

   function automatic void put_data_record();
      int unsigned len;
      int unsigned r;
      logic [15:0] want_upper;
      logic [15:0] off;
      r = $urandom_range(99);
      if (r < 10) begin
         len = 0;
      end else if (r < 12 && !long_record_sent) begin
         len = $urandom_range(128, 255);
         long_record_sent = 1'b1;
      end else begin
         len = $urandom_range(1, 16);
      end
      r = $urandom_range(99);
      if (r < 55) begin
         // Follow on from the last segment; past the top of memory go back to zero.
         if (gen_next[32]) begin
            want_upper = 16'h0000;
            off = 16'h0000;
         end else begin
            want_upper = gen_next[31:16];
            off = gen_next[15:0];
         end
      end else if (r < 65) begin
         want_upper = 16'hFFFF;
         off = 16'(0 - len);
      end else begin
         want_upper = $urandom_range(1) ? gen_upper : pick_upper();
         off = 16'($urandom);
      end
      if (want_upper != gen_upper) begin
         put_ext(want_upper);
      end
      rec_bytes = {};
      repeat (len) add_rec_byte(8'($urandom));
      put_record(REC_DATA, off, 8'd0);
      put_line_end();
      gen_next = {1'b0, want_upper, off} + 33'(len);
   endfunction

   function automatic void put_other_record();
      logic [7:0] typ;
      do begin
         typ = $urandom_range(1) ? 8'($urandom_range(2, 5)) : 8'($urandom);
      end while (typ == REC_DATA || typ == REC_EOF || typ == REC_EXT_LIN);
      rec_bytes = {};
      repeat ($urandom_range(0, 6)) add_rec_byte(8'($urandom));
      put_record(typ, 16'($urandom), 8'd0);
      put_line_end();
   endfunction

   // The load ends once; the seed decides how.
   function automatic void put_ending();
      case ($urandom_range(9))
         0, 1: begin
            rec_bytes = {};
            put_record(REC_EOF, 16'h0000, 8'd0);
            put_line_end();
         end
         2: put_eos();
         3: begin
            rec_bytes = {8'($urandom)};
            put_record(REC_DATA, 16'($urandom), 8'd0);
            put_eos();
         end
         4: begin
            put_char(CHAR_COLON);
            repeat ($urandom_range(0, 7)) put_char(digit_char(4'($urandom)));
            put_eos();
         end
         5: begin
            logic [7:0] c;
            do begin
               c = 8'($urandom);
            end while (c == CHAR_COLON || c == CHAR_LF || c == CHAR_CR);
            put_char(c);
         end
         6: begin
            put_char(CHAR_COLON);
            repeat ($urandom_range(0, 7)) put_char(digit_char(4'($urandom)));
            put_char(pick_non_hex());
         end
         7: begin
            put_char(CHAR_COLON);
            put_hex_byte(8'd4);
            put_hex_byte(8'($urandom));
            put_hex_byte(8'($urandom));
            put_hex_byte(REC_DATA);
            repeat ($urandom_range(0, 9)) put_char(digit_char(4'($urandom)));
            case ($urandom_range(2))
               0: add_text_char({CHAR_LF, 1'b0});
               1: put_char(pick_non_hex());
               default: put_eos();
            endcase
         end
         8: begin
            rec_bytes = {};
            repeat ($urandom_range(0, 4)) add_rec_byte(8'($urandom));
            put_record(REC_DATA, 16'($urandom), 8'($urandom_range(1, 255)));
            put_line_end();
         end
         default: begin
            rec_bytes = {};
            case ($urandom_range(2))
               0: ;
               1: add_rec_byte(8'($urandom));
               default: repeat (3) add_rec_byte(8'($urandom));
            endcase
            put_record(REC_EXT_LIN, 16'h0000, 8'd0);
            put_line_end();
         end
      endcase
   endfunction

   function automatic void build_text();
      int unsigned r;
      // Opening lines: a blank line, the top address page and a record that
      // wraps past the top of memory.
      add_text_char({CHAR_CR, 1'b0});
      add_text_char({CHAR_LF, 1'b0});
      put_ext(16'hFFFF);
      rec_bytes = {8'h00, 8'hFF};
      put_record(REC_DATA, 16'hFFFF, 8'd0);
      put_line_end();
      gen_next = 33'h1_0000_0001;
      while (file_text.size() < TEXT_CHARS) begin
         r = $urandom_range(99);
         if (r < 65) begin
            put_data_record();
         end else if (r < 77) begin
            put_ext(pick_upper());
         end else if (r < 89) begin
            put_other_record();
         end else begin
            if ($urandom_range(1)) begin
               add_text_char({CHAR_CR, 1'b0});
            end
            add_text_char({CHAR_LF, 1'b0});
         end
      end
      put_ending();
      // The parser must stay silent after its final result.
      repeat (NOISE_CHARS) add_text_char({8'($urandom), 1'($urandom_range(1))});
   endfunction

   task automatic send_text();
      int unsigned mode;
      foreach (file_text[i]) begin
         mode = (i / MODE_SPAN) % 4;
         case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 10; stall_pct = 10; end
         endcase
         if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while ($urandom_range(99) < idle_pct) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_ch <= file_text[i].ch;
         req_end_of_stream <= file_text[i].eos;
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      build_text();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      send_text();
      while (load_tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (load_tracker.faults == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
